// File: rtl/core/tmqt_pkg.sv
// Shared types, codes and reset constants for the typed message queue table.
// Used by tmqt_front, tmqt_back, the top level and the checker.
package tmqt_pkg;

    localparam int DEF_QUEUES    = 16;
    localparam int DEF_MSG_SLOTS = 64;

    localparam logic [8:0]  MODE_MASK     = 9'h1FF;
    localparam logic [15:0] LIMIT_RST     = 16'd4096;
    localparam logic [13:0] MAX_BYTES_RST = 14'd1024;
    localparam logic [6:0]  MSG_CNT_MAX   = 7'd127;

    localparam logic [1:0] CFG_DEFAULT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_MAX_BYTES     = 2'd1;

    localparam logic [2:0] K_GET    = 3'd0;
    localparam logic [2:0] K_SEND   = 3'd1;
    localparam logic [2:0] K_RECV   = 3'd2;
    localparam logic [2:0] K_STAT   = 3'd3;
    localparam logic [2:0] K_SET    = 3'd4;
    localparam logic [2:0] K_REMOVE = 3'd5;

    localparam logic [3:0] S_OK            = 4'd0;
    localparam logic [3:0] S_BAD_QUEUE     = 4'd1;
    localparam logic [3:0] S_NO_KEY        = 4'd2;
    localparam logic [3:0] S_NO_SLOT       = 4'd3;
    localparam logic [3:0] S_BAD_SIZE      = 4'd4;
    localparam logic [3:0] S_FULL_NOWAIT   = 4'd5;
    localparam logic [3:0] S_FULL_BLOCKED  = 4'd6;
    localparam logic [3:0] S_TOO_LARGE     = 4'd7;
    localparam logic [3:0] S_EMPTY_NOWAIT  = 4'd8;
    localparam logic [3:0] S_EMPTY_BLOCKED = 4'd9;
    localparam logic [3:0] S_POOL_FULL     = 4'd10;

    // Decoded command as it sits in the front queue
    typedef struct packed {
        logic [2:0]  kind;
        logic        bad;
        logic        size_bad;
        logic [31:0] key;
        logic        create_flag;
        logic [8:0]  mode_bits;
        logic [3:0]  queue_id;
        logic [31:0] msg_type;
        logic [13:0] byte_count;
        logic        nowait;
        logic [31:0] payload;
        logic [15:0] new_limit;
        logic [15:0] pid;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  q;
        logic [31:0] mtype;
        logic [13:0] size;
        logic [31:0] payload;
    } slot_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  queue_id_out;
        logic [31:0] msg_type_out;
        logic [13:0] byte_count_out;
        logic [31:0] payload_out;
        logic [6:0]  msg_total;
        logic [15:0] queue_bytes;
        logic [15:0] queue_limit;
        logic [8:0]  mode_out;
        logic [15:0] last_sender;
        logic [15:0] last_receiver;
    } result_t;

endpackage

// File: rtl/core/tmqt_front.sv
// Front end: accepts input transfers, classifies them and holds them in a
// two-entry command queue. Depends on tmqt_pkg.
module tmqt_front import tmqt_pkg::*; #(
    parameter int QUEUES = DEF_QUEUES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_key,
    input  logic        s_create_flag,
    input  logic [8:0]  s_mode_bits,
    input  logic [3:0]  s_queue_id,
    input  logic [31:0] s_msg_type,
    input  logic [13:0] s_byte_count,
    input  logic        s_nowait,
    input  logic [31:0] s_payload,
    input  logic [15:0] s_new_limit,
    input  logic [15:0] s_pid,
    input  logic [13:0] max_bytes,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);
    localparam int QLIM = (QUEUES < 16) ? QUEUES : 16;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       dec;
    logic       push;

    always_comb begin
        dec.kind        = s_kind;
        dec.bad         = (s_kind != K_GET) &&
                          ((s_kind > K_REMOVE) || ({1'b0, s_queue_id} >= 5'(QLIM)));
        dec.size_bad    = (s_byte_count == 14'd0) || (s_byte_count > max_bytes);
        dec.key         = s_key;
        dec.create_flag = s_create_flag;
        dec.mode_bits   = s_mode_bits & MODE_MASK;
        dec.queue_id    = s_queue_id;
        dec.msg_type    = s_msg_type;
        dec.byte_count  = s_byte_count;
        dec.nowait      = s_nowait;
        dec.payload     = s_payload;
        dec.new_limit   = s_new_limit;
        dec.pid         = s_pid;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, cmd_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/tmqt_back.sv
// Back end: executes commands against the queue table and the message pool,
// and holds the result register. Depends on tmqt_pkg.
module tmqt_back import tmqt_pkg::*; #(
    parameter int QUEUES    = DEF_QUEUES,
    parameter int MSG_SLOTS = DEF_MSG_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic [15:0] default_limit,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    localparam int QLIM = (QUEUES < 16) ? QUEUES : 16;
    localparam int QW   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int SA   = $clog2(MSG_SLOTS);
    localparam int CW   = $clog2(MSG_SLOTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GSCAN  = 3'd1;
    localparam logic [2:0] ST_GEND   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_RSCAN  = 3'd4;
    localparam logic [2:0] ST_RDONE  = 3'd5;
    localparam logic [2:0] ST_PACK   = 3'd6;
    localparam logic [2:0] ST_REPORT = 3'd7;

    // queue table
    logic        q_act_reg  [QUEUES];
    logic [31:0] q_key_reg  [QUEUES];
    logic [8:0]  q_mode_reg [QUEUES];
    logic [6:0]  q_cnt_reg  [QUEUES];
    logic [15:0] q_bytes_reg[QUEUES];
    logic [15:0] q_lim_reg  [QUEUES];
    logic [15:0] q_snd_reg  [QUEUES];
    logic [15:0] q_rcv_reg  [QUEUES];

    // message pool, kept packed in arrival order below arrival_reg
    slot_t       mem [MSG_SLOTS];
    slot_t       rd_data_reg;

    logic [2:0]  state_reg;
    cmd_t        cmd_reg;
    logic [QW-1:0] cur_q_reg;
    logic [QW-1:0] free_q_reg;
    logic        free_found_reg;
    logic [CW-1:0] arrival_reg;
    logic [CW-1:0] rptr_reg;
    logic [CW-1:0] wptr_reg;
    logic [CW-1:0] iss_idx_reg;
    logic        iss_valid_reg;
    logic        drop_pick_reg;
    logic        found_reg;
    logic [CW-1:0] pick_idx_reg;
    slot_t       pick_reg;
    logic [3:0]  status_reg;
    logic        report_reg;
    logic [31:0] r_type_reg;
    logic [13:0] r_bytes_reg;
    logic [31:0] r_payload_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic        a_act;
    logic [6:0]  a_cnt;
    logic [15:0] a_bytes;
    logic [15:0] a_lim;
    logic        over_quota;
    logic        pool_full;
    logic        send_ok;
    logic        issue_ok;
    logic        ent_q_hit;
    logic        exact_hit;
    logic        neg_take;
    logic        drop;
    logic        mem_we;
    logic [SA-1:0] mem_wa;
    slot_t       mem_wd;
    logic signed [32:0] t33;
    logic signed [32:0] nsel33;

    assign a_act   = q_act_reg[cur_q_reg];
    assign a_cnt   = q_cnt_reg[cur_q_reg];
    assign a_bytes = q_bytes_reg[cur_q_reg];
    assign a_lim   = q_lim_reg[cur_q_reg];

    assign over_quota = ({1'b0, a_bytes} + {3'b000, cmd_reg.byte_count}) > {1'b0, a_lim};
    assign pool_full  = (arrival_reg == CW'(MSG_SLOTS)) || (a_cnt >= MSG_CNT_MAX);
    assign send_ok    = (state_reg == ST_CHECK) && a_act && (cmd_reg.kind == K_SEND) &&
                        !cmd_reg.size_bad && !over_quota && !pool_full;

    assign issue_ok  = (rptr_reg != arrival_reg);
    assign ent_q_hit = (rd_data_reg.q == cmd_reg.queue_id);

    assign t33    = {rd_data_reg.mtype[31], rd_data_reg.mtype};
    assign nsel33 = 33'sd0 - $signed({cmd_reg.msg_type[31], cmd_reg.msg_type});

    assign exact_hit = iss_valid_reg && ent_q_hit &&
                       ((cmd_reg.msg_type == 32'd0) ||
                        (!cmd_reg.msg_type[31] && (rd_data_reg.mtype == cmd_reg.msg_type)));
    // negative selector: keep the lowest type seen, the first of equals
    assign neg_take  = iss_valid_reg && ent_q_hit && cmd_reg.msg_type[31] &&
                       (t33 <= nsel33) &&
                       (!found_reg || ($signed(rd_data_reg.mtype) < $signed(pick_reg.mtype)));

    assign drop = drop_pick_reg ? (iss_idx_reg == pick_idx_reg) : ent_q_hit;

    always_comb begin
        if (state_reg == ST_PACK) begin
            mem_we = iss_valid_reg && !drop;
            mem_wa = wptr_reg[SA-1:0];
            mem_wd = rd_data_reg;
        end else begin
            mem_we     = send_ok;
            mem_wa     = arrival_reg[SA-1:0];
            mem_wd.q       = cmd_reg.queue_id;
            mem_wd.mtype   = cmd_reg.msg_type;
            mem_wd.size    = cmd_reg.byte_count;
            mem_wd.payload = cmd_reg.payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rptr_reg[SA-1:0]];
    end

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            arrival_reg   <= '0;
            res_valid_reg <= 1'b0;
            iss_valid_reg <= 1'b0;
            for (int i = 0; i < QUEUES; i++) begin
                q_act_reg[i] <= 1'b0;
            end
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd_pop) begin
                        cmd_reg        <= cmd;
                        r_type_reg     <= '0;
                        r_bytes_reg    <= '0;
                        r_payload_reg  <= '0;
                        status_reg     <= S_OK;
                        report_reg     <= 1'b0;
                        free_found_reg <= 1'b0;
                        if (cmd.kind == K_GET) begin
                            cur_q_reg <= '0;
                            state_reg <= ST_GSCAN;
                        end else if (cmd.bad) begin
                            status_reg <= S_BAD_QUEUE;
                            state_reg  <= ST_REPORT;
                        end else begin
                            cur_q_reg <= QW'(cmd.queue_id);
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_GSCAN: begin
                    if (a_act && (q_key_reg[cur_q_reg] == cmd_reg.key)) begin
                        report_reg <= 1'b1;
                        state_reg  <= ST_REPORT;
                    end else begin
                        if (!a_act && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_q_reg     <= cur_q_reg;
                        end
                        if (cur_q_reg == QW'(QLIM - 1)) begin
                            state_reg <= ST_GEND;
                        end else begin
                            cur_q_reg <= cur_q_reg + QW'(1);
                        end
                    end
                end
                ST_GEND: begin
                    if (!cmd_reg.create_flag) begin
                        status_reg <= S_NO_KEY;
                    end else if (!free_found_reg) begin
                        status_reg <= S_NO_SLOT;
                    end else begin
                        q_act_reg[free_q_reg]   <= 1'b1;
                        q_key_reg[free_q_reg]   <= cmd_reg.key;
                        q_mode_reg[free_q_reg]  <= cmd_reg.mode_bits;
                        q_cnt_reg[free_q_reg]   <= '0;
                        q_bytes_reg[free_q_reg] <= '0;
                        q_lim_reg[free_q_reg]   <= default_limit;
                        q_snd_reg[free_q_reg]   <= '0;
                        q_rcv_reg[free_q_reg]   <= '0;
                        cur_q_reg               <= free_q_reg;
                        report_reg              <= 1'b1;
                    end
                    state_reg <= ST_REPORT;
                end
                ST_CHECK: begin
                    if (!a_act) begin
                        status_reg <= S_BAD_QUEUE;
                        state_reg  <= ST_REPORT;
                    end else begin
                        report_reg <= 1'b1;
                        state_reg  <= ST_REPORT;
                        case (cmd_reg.kind)
                            K_SEND: begin
                                if (cmd_reg.size_bad) begin
                                    status_reg <= S_BAD_SIZE;
                                end else if (over_quota) begin
                                    status_reg <= cmd_reg.nowait ? S_FULL_NOWAIT
                                                                 : S_FULL_BLOCKED;
                                end else if (pool_full) begin
                                    status_reg <= S_POOL_FULL;
                                end else begin
                                    arrival_reg            <= arrival_reg + CW'(1);
                                    q_cnt_reg[cur_q_reg]   <= a_cnt + 7'd1;
                                    q_bytes_reg[cur_q_reg] <= a_bytes +
                                                              {2'b00, cmd_reg.byte_count};
                                    q_snd_reg[cur_q_reg]   <= cmd_reg.pid;
                                    r_bytes_reg            <= cmd_reg.byte_count;
                                end
                            end
                            K_RECV: begin
                                rptr_reg      <= '0;
                                iss_valid_reg <= 1'b0;
                                found_reg     <= 1'b0;
                                state_reg     <= ST_RSCAN;
                            end
                            K_SET: begin
                                q_mode_reg[cur_q_reg] <= cmd_reg.mode_bits;
                                q_lim_reg[cur_q_reg]  <= cmd_reg.new_limit;
                            end
                            K_REMOVE: begin
                                q_act_reg[cur_q_reg]   <= 1'b0;
                                q_key_reg[cur_q_reg]   <= '0;
                                q_mode_reg[cur_q_reg]  <= '0;
                                q_cnt_reg[cur_q_reg]   <= '0;
                                q_bytes_reg[cur_q_reg] <= '0;
                                q_lim_reg[cur_q_reg]   <= '0;
                                q_snd_reg[cur_q_reg]   <= '0;
                                q_rcv_reg[cur_q_reg]   <= '0;
                                rptr_reg               <= '0;
                                wptr_reg               <= '0;
                                drop_pick_reg          <= 1'b0;
                                iss_valid_reg          <= 1'b0;
                                state_reg              <= ST_PACK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RSCAN: begin
                    if (exact_hit || neg_take) begin
                        found_reg    <= 1'b1;
                        pick_idx_reg <= iss_idx_reg;
                        pick_reg     <= rd_data_reg;
                    end
                    if (exact_hit || (!iss_valid_reg && !issue_ok)) begin
                        iss_valid_reg <= 1'b0;
                        state_reg     <= ST_RDONE;
                    end else begin
                        iss_valid_reg <= issue_ok;
                        iss_idx_reg   <= rptr_reg;
                        if (issue_ok) begin
                            rptr_reg <= rptr_reg + CW'(1);
                        end
                    end
                end
                ST_RDONE: begin
                    report_reg <= 1'b1;
                    state_reg  <= ST_REPORT;
                    if (!found_reg) begin
                        status_reg <= cmd_reg.nowait ? S_EMPTY_NOWAIT : S_EMPTY_BLOCKED;
                    end else if (pick_reg.size > cmd_reg.byte_count) begin
                        status_reg  <= S_TOO_LARGE;
                        r_bytes_reg <= pick_reg.size;
                    end else begin
                        r_type_reg             <= pick_reg.mtype;
                        r_bytes_reg            <= pick_reg.size;
                        r_payload_reg          <= pick_reg.payload;
                        q_cnt_reg[cur_q_reg]   <= a_cnt - 7'd1;
                        q_bytes_reg[cur_q_reg] <= a_bytes - {2'b00, pick_reg.size};
                        q_rcv_reg[cur_q_reg]   <= cmd_reg.pid;
                        // close the gap left by the taken message
                        rptr_reg               <= pick_idx_reg;
                        wptr_reg               <= pick_idx_reg;
                        drop_pick_reg          <= 1'b1;
                        iss_valid_reg          <= 1'b0;
                        state_reg              <= ST_PACK;
                    end
                end
                ST_PACK: begin
                    if (iss_valid_reg && !drop) begin
                        wptr_reg <= wptr_reg + CW'(1);
                    end
                    if (!iss_valid_reg && !issue_ok) begin
                        arrival_reg <= wptr_reg;
                        state_reg   <= ST_REPORT;
                    end else begin
                        iss_valid_reg <= issue_ok;
                        iss_idx_reg   <= rptr_reg;
                        if (issue_ok) begin
                            rptr_reg <= rptr_reg + CW'(1);
                        end
                    end
                end
                ST_REPORT: begin
                    res_reg.status         <= status_reg;
                    res_reg.msg_type_out   <= r_type_reg;
                    res_reg.byte_count_out <= r_bytes_reg;
                    res_reg.payload_out    <= r_payload_reg;
                    if (report_reg) begin
                        res_reg.queue_id_out  <= 4'(cur_q_reg);
                        res_reg.msg_total     <= a_cnt;
                        res_reg.queue_bytes   <= a_bytes;
                        res_reg.queue_limit   <= a_lim;
                        res_reg.mode_out      <= q_mode_reg[cur_q_reg];
                        res_reg.last_sender   <= q_snd_reg[cur_q_reg];
                        res_reg.last_receiver <= q_rcv_reg[cur_q_reg];
                    end else begin
                        res_reg.queue_id_out  <= '0;
                        res_reg.msg_total     <= '0;
                        res_reg.queue_bytes   <= '0;
                        res_reg.queue_limit   <= '0;
                        res_reg.mode_out      <= '0;
                        res_reg.last_sender   <= '0;
                        res_reg.last_receiver <= '0;
                    end
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/typed_message_queue_table.sv
// Top level of the typed message queue table: configuration registers,
// front command queue and back executor. Depends on tmqt_pkg, tmqt_front, tmqt_back.
//
//  channel | direction | handshake          | contents
//  s_      | in        | s_valid / s_ready  | one command (kind, key, ids, message)
//  m_      | out       | m_valid / m_ready  | one result per command
//  cfg_    | in        | cfg_we             | register index and write data
//
// Per command: get scans the queue table; send, stat and set act on one queue
// entry; receive scans the pool and, when it takes a message, repacks the pool
// from the taken slot; remove repacks the whole pool. The pool memory has one
// read and one write port. Reset is synchronous and needs no clearing pass.
// The two-entry command queue keeps taking transfers, until it is full, while a
// result waits on m_ready.
module typed_message_queue_table import tmqt_pkg::*; #(
    parameter int QUEUES    = DEF_QUEUES,
    parameter int MSG_SLOTS = DEF_MSG_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_key,
    input  logic        s_create_flag,
    input  logic [8:0]  s_mode_bits,
    input  logic [3:0]  s_queue_id,
    input  logic [31:0] s_msg_type,
    input  logic [13:0] s_byte_count,
    input  logic        s_nowait,
    input  logic [31:0] s_payload,
    input  logic [15:0] s_new_limit,
    input  logic [15:0] s_pid,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [3:0]  m_queue_id_out,
    output logic [31:0] m_msg_type_out,
    output logic [13:0] m_byte_count_out,
    output logic [31:0] m_payload_out,
    output logic [6:0]  m_msg_total,
    output logic [15:0] m_queue_bytes,
    output logic [15:0] m_queue_limit,
    output logic [8:0]  m_mode_out,
    output logic [15:0] m_last_sender,
    output logic [15:0] m_last_receiver
);
    logic [15:0] default_limit_reg;
    logic [13:0] max_bytes_reg;
    logic        cmd_valid;
    logic        cmd_pop;
    cmd_t        cmd;
    result_t     res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_limit_reg <= LIMIT_RST;
            max_bytes_reg     <= MAX_BYTES_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DEFAULT_LIMIT: default_limit_reg <= cfg_wdata;
                CFG_MAX_BYTES:     max_bytes_reg     <= cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    tmqt_front #(.QUEUES(QUEUES)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_create_flag (s_create_flag),
        .s_mode_bits   (s_mode_bits),
        .s_queue_id    (s_queue_id),
        .s_msg_type    (s_msg_type),
        .s_byte_count  (s_byte_count),
        .s_nowait      (s_nowait),
        .s_payload     (s_payload),
        .s_new_limit   (s_new_limit),
        .s_pid         (s_pid),
        .max_bytes     (max_bytes_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    tmqt_back #(.QUEUES(QUEUES), .MSG_SLOTS(MSG_SLOTS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .default_limit (default_limit_reg),
        .res_valid     (m_valid),
        .res_ready     (m_ready),
        .res           (res)
    );

    assign m_status         = res.status;
    assign m_queue_id_out   = res.queue_id_out;
    assign m_msg_type_out   = res.msg_type_out;
    assign m_byte_count_out = res.byte_count_out;
    assign m_payload_out    = res.payload_out;
    assign m_msg_total      = res.msg_total;
    assign m_queue_bytes    = res.queue_bytes;
    assign m_queue_limit    = res.queue_limit;
    assign m_mode_out       = res.mode_out;
    assign m_last_sender    = res.last_sender;
    assign m_last_receiver  = res.last_receiver;

endmodule

// File: rtl/core/tmqt_checker.sv
// Port-level checks for typed_message_queue_table, bound to the top level.
// Depends on tmqt_pkg.
module tmqt_checker import tmqt_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_status,
    input logic [3:0]  m_queue_id_out,
    input logic [13:0] m_byte_count_out,
    input logic [31:0] m_payload_out,
    input logic [31:0] m_msg_type_out,
    input logic [6:0]  m_msg_total,
    input logic [15:0] m_queue_limit
);
    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_payload_out))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == S_BAD_QUEUE || m_status == S_NO_KEY ||
                    m_status == S_NO_SLOT) |->
        m_queue_id_out == 4'd0 && m_msg_total == 7'd0 && m_queue_limit == 16'd0 &&
        m_byte_count_out == 14'd0)
        else $error("error result carries queue fields");

    a_too_large: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == S_TOO_LARGE |->
        m_byte_count_out != 14'd0 && m_payload_out == 32'd0 && m_msg_type_out == 32'd0)
        else $error("too-large result malformed");

    a_fail_no_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == S_FULL_NOWAIT || m_status == S_FULL_BLOCKED ||
                    m_status == S_EMPTY_NOWAIT || m_status == S_EMPTY_BLOCKED ||
                    m_status == S_POOL_FULL || m_status == S_BAD_SIZE) |->
        m_byte_count_out == 14'd0 && m_payload_out == 32'd0)
        else $error("failed transfer reports message data");

endmodule

bind typed_message_queue_table tmqt_checker u_tmqt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_queue_id_out   (m_queue_id_out),
    .m_byte_count_out (m_byte_count_out),
    .m_payload_out    (m_payload_out),
    .m_msg_type_out   (m_msg_type_out),
    .m_msg_total      (m_msg_total),
    .m_queue_limit    (m_queue_limit)
);
